FILE: hdl/ibbl_pkg.sv
`default_nettype none

package ibbl_pkg;

	// Field and configuration widths
	localparam int GRID_MAX = 4096;
	localparam int CFG_W    = 13;
	localparam int POS_W    = 12;
	localparam int DIR_W    = 2;
	localparam int WF_W     = 17;
	localparam int F_W      = 24;
	localparam int UP_W     = 14;
	localparam int ADDR_W   = 2;

	// Q1.16 unity and the interpolation arithmetic widths
	localparam int Q_ONE    = 65536;
	localparam int Q_HALF   = 32768;
	localparam int A_W      = 17;              // weight on f_here
	localparam int B_W      = 18;              // weight on the second term
	localparam int DEN_W    = 18;              // rounding divisor
	localparam int PA_W     = F_W + A_W + 1;
	localparam int PB_W     = F_W + B_W + 1;
	localparam int NUM_W    = PB_W + 1;
	localparam int N_W      = NUM_W + 1;
	localparam int MAG_W    = N_W - 2;

	// Pipelined restoring divider
	localparam int QUO_W      = 25;
	localparam int DIV_W      = DEN_W + 1;
	localparam int DIV_STEPS  = 5;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_GRID_WIDTH     = 2'd0;
	localparam logic [ADDR_W-1:0] REG_GRID_HEIGHT    = 2'd1;
	localparam logic [ADDR_W-1:0] REG_PERIODIC_WIDTH = 2'd2;

	typedef enum logic [1:0] {
		RULE_NEAR = 2'd0,
		RULE_HALF = 2'd1,
		RULE_FAR  = 2'd2
	} rule_t;

	typedef struct packed {
		logic [CFG_W-1:0] grid_width;
		logic [CFG_W-1:0] grid_height;
		logic [CFG_W-1:0] periodic_width;
	} cfg_t;

	typedef struct packed {
		logic        [POS_W-1:0] pos_x;
		logic        [POS_W-1:0] pos_y;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic        [WF_W-1:0]  wall_fraction;
		logic signed [F_W-1:0]   f_here;
		logic signed [F_W-1:0]   f_upstream;
		logic signed [F_W-1:0]   f_here_opposite;
	} link_t;

	// Sideband that rides along with the division
	typedef struct packed {
		rule_t                  rule;
		logic signed [UP_W-1:0] ux;
		logic signed [UP_W-1:0] uy;
		logic                   neg;
	} side_t;

endpackage

`default_nettype wire

FILE: hdl/ibbl_if.sv
`default_nettype none

interface ibbl_link_if;
	import ibbl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic        [POS_W-1:0] pos_x;
	logic        [POS_W-1:0] pos_y;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic        [WF_W-1:0]  wall_fraction;
	logic signed [F_W-1:0]   f_here;
	logic signed [F_W-1:0]   f_upstream;
	logic signed [F_W-1:0]   f_here_opposite;

	modport source (output valid, pos_x, pos_y, dir_x, dir_y, wall_fraction,
		f_here, f_upstream, f_here_opposite, input ready);
	modport sink (input valid, pos_x, pos_y, dir_x, dir_y, wall_fraction,
		f_here, f_upstream, f_here_opposite, output ready);
endinterface

interface ibbl_result_if;
	import ibbl_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [F_W-1:0]  f_new;
	logic        [1:0]      rule_used;
	logic signed [UP_W-1:0] upstream_x;
	logic signed [UP_W-1:0] upstream_y;

	modport source (output valid, f_new, rule_used, upstream_x, upstream_y,
		input ready);
	modport sink (input valid, f_new, rule_used, upstream_x, upstream_y,
		output ready);
endinterface

interface ibbl_cfg_if;
	import ibbl_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] addr;
	logic [CFG_W-1:0]  wdata;

	modport source (output valid, addr, wdata, input ready);
	modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

FILE: hdl/ibbl_front.sv
`default_nettype none

module ibbl_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  ibbl_pkg::cfg_t                 cfg,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  ibbl_pkg::link_t                in_link,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [ibbl_pkg::MAG_W-1:0]     out_mag,
	output logic [ibbl_pkg::DIV_W-1:0]     out_den2,
	output ibbl_pkg::side_t                out_side
);
	import ibbl_pkg::*;

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	// Stage 1 registers
	logic signed [UP_W-1:0] ux_s1, uy_s1;
	logic        [WF_W-1:0] wf_s1;
	logic signed [F_W-1:0]  fh_s1, fu_s1, fo_s1;

	// Stage 2 registers
	logic signed [PA_W-1:0] pa_s2;
	logic signed [PB_W-1:0] pb_s2;
	logic        [DEN_W-1:0] den_s2;
	rule_t                  rule_s2;
	logic signed [UP_W-1:0] ux_s2, uy_s2;

	// Stage 3 registers
	logic [MAG_W-1:0] mag_s3;
	logic [DIV_W-1:0] den2_s3;
	side_t            side_s3;

	// Stage enables: a stage moves when empty or when the next one moves
	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Stage 1: upstream cell and optional periodic wrap on x
	logic signed [UP_W-1:0] ux0, ux_w, uy0, per;

	always_comb begin
		ux0 = $signed({2'b00, in_link.pos_x}) -
			$signed({{(UP_W-DIR_W){in_link.dir_x[DIR_W-1]}}, in_link.dir_x});
		uy0 = $signed({2'b00, in_link.pos_y}) -
			$signed({{(UP_W-DIR_W){in_link.dir_y[DIR_W-1]}}, in_link.dir_y});
		per = $signed({1'b0, cfg.periodic_width});
		ux_w = ux0;
		if (cfg.periodic_width != '0) begin
			if (ux0 < 0)
				ux_w = ux0 + per;
			else if (ux0 >= per)
				ux_w = ux0 - per;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ux_s1 <= ux_w;
			uy_s1 <= uy0;
			wf_s1 <= in_link.wall_fraction;
			fh_s1 <= in_link.f_here;
			fu_s1 <= in_link.f_upstream;
			fo_s1 <= in_link.f_here_opposite;
		end
	end

	// Stage 2: pick the rule, its weights and divisor, then multiply
	logic                   in_grid, near;
	logic [A_W-1:0]         wa;
	logic [B_W-1:0]         wb;
	logic [DEN_W-1:0]       den, d2;
	logic [DEN_W-1:0]       t2;
	logic signed [F_W-1:0]  g;
	rule_t                  rule;

	always_comb begin
		in_grid = (ux_s1 >= 0) && (ux_s1 < $signed({1'b0, cfg.grid_width})) &&
			(uy_s1 >= 0) && (uy_s1 < $signed({1'b0, cfg.grid_height}));
		near = (wf_s1 < WF_W'(Q_HALF));
		t2 = {1'b0, wf_s1[WF_W-2:0], 1'b0};
		d2 = {wf_s1, 1'b0};
		if (near && in_grid) begin
			rule = RULE_NEAR;
			wa   = A_W'(t2);
			wb   = B_W'(Q_ONE) - t2;
			g    = fu_s1;
			den  = DEN_W'(Q_ONE);
		end else if (near) begin
			rule = RULE_HALF;
			wa   = A_W'(Q_ONE);
			wb   = '0;
			g    = fu_s1;
			den  = DEN_W'(Q_ONE);
		end else begin
			rule = RULE_FAR;
			wa   = A_W'(Q_ONE);
			wb   = d2 - B_W'(Q_ONE);
			g    = fo_s1;
			den  = d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			pa_s2   <= fh_s1 * $signed({1'b0, wa});
			pb_s2   <= g * $signed({1'b0, wb});
			den_s2  <= den;
			rule_s2 <= rule;
			ux_s2   <= ux_s1;
			uy_s2   <= uy_s1;
		end
	end

	// Stage 3: numerator with rounding offset, folded to a magnitude
	logic signed [N_W-1:0] nsum;
	logic                  nneg;

	always_comb begin
		nsum = ($signed({{(N_W-PA_W){pa_s2[PA_W-1]}}, pa_s2}) +
			$signed({{(N_W-PB_W){pb_s2[PB_W-1]}}, pb_s2})) * 2 +
			$signed({{(N_W-DEN_W){1'b0}}, den_s2});
		nneg = nsum[N_W-1];
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			mag_s3       <= nneg ? MAG_W'(~nsum) : MAG_W'(nsum);
			den2_s3      <= {den_s2, 1'b0};
			side_s3.rule <= rule_s2;
			side_s3.ux   <= ux_s2;
			side_s3.uy   <= uy_s2;
			side_s3.neg  <= nneg;
		end
	end

	assign out_valid = v_s3;
	assign out_mag   = mag_s3;
	assign out_den2  = den2_s3;
	assign out_side  = side_s3;

`ifndef ASSERT_OFF
	a_far_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rule_s2 == RULE_FAR |-> den_s2 >= DEN_W'(Q_ONE))
		else $error("far rule with divisor below one");
	a_near_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rule_s2 != RULE_FAR |-> den_s2 == DEN_W'(Q_ONE))
		else $error("near or halfway rule with divisor other than one");
	a_half_pb: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rule_s2 == RULE_HALF |-> pb_s2 == '0)
		else $error("halfway rule carries a second term");
`endif

endmodule

`default_nettype wire

FILE: hdl/ibbl_divider.sv
`default_nettype none

module ibbl_divider (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [ibbl_pkg::MAG_W-1:0]     in_mag,
	input  wire  [ibbl_pkg::DIV_W-1:0]     in_den2,
	input  ibbl_pkg::side_t                in_side,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [ibbl_pkg::QUO_W-1:0]     out_quo,
	output ibbl_pkg::side_t                out_side
);
	import ibbl_pkg::*;

	// Per-stage registers: partial remainder, shifting dividend/quotient word
	logic             v_s    [DIV_STAGES];
	logic [DIV_W-1:0] rem_s  [DIV_STAGES];
	logic [QUO_W-1:0] sh_s   [DIV_STAGES];
	logic [DIV_W-1:0] den_s  [DIV_STAGES];
	side_t            side_s [DIV_STAGES];
	logic             en     [DIV_STAGES];

	logic             v_in    [DIV_STAGES];
	logic [DIV_W-1:0] rem_in  [DIV_STAGES];
	logic [QUO_W-1:0] sh_in   [DIV_STAGES];
	logic [DIV_W-1:0] den_in  [DIV_STAGES];
	side_t            side_in [DIV_STAGES];
	logic [DIV_W-1:0] rem_nx  [DIV_STAGES];
	logic [QUO_W-1:0] sh_nx   [DIV_STAGES];

	// Stage enables, from the output back to the input
	always_comb begin
		en[DIV_STAGES-1] = !v_s[DIV_STAGES-1] || out_ready;
		for (int k = DIV_STAGES - 2; k >= 0; k--)
			en[k] = !v_s[k] || en[k+1];
	end
	assign in_ready = en[0];

	// Stage inputs: the first stage takes the dividend's top bits as remainder
	assign v_in[0]    = in_valid;
	assign rem_in[0]  = DIV_W'(in_mag[MAG_W-1:QUO_W]);
	assign sh_in[0]   = in_mag[QUO_W-1:0];
	assign den_in[0]  = in_den2;
	assign side_in[0] = in_side;

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_link
		assign v_in[k]    = v_s[k-1];
		assign rem_in[k]  = rem_s[k-1];
		assign sh_in[k]   = sh_s[k-1];
		assign den_in[k]  = den_s[k-1];
		assign side_in[k] = side_s[k-1];
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		// Run DIV_STEPS restoring steps: shift in a bit, subtract if it fits
		always_comb begin : p_steps
			logic [DIV_W:0]   t;
			logic [DIV_W-1:0] r;
			logic [QUO_W-1:0] s;
			logic             ge;
			r = rem_in[k];
			s = sh_in[k];
			for (int j = 0; j < DIV_STEPS; j++) begin
				t  = {r, s[QUO_W-1]};
				ge = (t >= {1'b0, den_in[k]});
				r  = ge ? DIV_W'(t - {1'b0, den_in[k]}) : DIV_W'(t);
				s  = {s[QUO_W-2:0], ge};
			end
			rem_nx[k] = r;
			sh_nx[k]  = s;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en[k])
				v_s[k] <= v_in[k];
		end

		always_ff @(posedge clk) begin
			if (en[k] && v_in[k]) begin
				rem_s[k]  <= rem_nx[k];
				sh_s[k]   <= sh_nx[k];
				den_s[k]  <= den_in[k];
				side_s[k] <= side_in[k];
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign out_quo   = sh_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

`ifndef ASSERT_OFF
	a_fits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> DIV_W'(in_mag[MAG_W-1:QUO_W]) < in_den2)
		else $error("quotient does not fit the divider width");
	a_rem_first: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> rem_s[0] < den_s[0])
		else $error("partial remainder not below divisor");
	a_rem_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[DIV_STAGES-1] |-> rem_s[DIV_STAGES-1] < den_s[DIV_STAGES-1])
		else $error("final remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: hdl/interpolated_bounce_back_link_unit.sv
`default_nettype none

// Channel   Dir  Handshake     Word
// links     in   valid/ready   cell position, direction, wall fraction, three f values
// results   out  valid/ready   f_new, rule_used, upstream_x, upstream_y
// cfg       in   valid/ready   addr (register index), wdata (13 bits); always ready
//
// One link enters per cycle barring stalls. There are three front stages
// (wrap, multiply, numerator), five divider stages of five quotient bits
// each, and the output register. The 25-bit quotient of the rounding
// division sets the divider depth. Reset clears all valid bits and loads
// the registers with their reset values. Each stage moves on its own when
// its successor has room, so bubbles close up behind a stalled output.
module interpolated_bounce_back_link_unit (
	input  wire             clk,
	input  wire             arst_n,
	ibbl_link_if.sink       links,
	ibbl_result_if.source   results,
	ibbl_cfg_if.sink        cfg
);
	import ibbl_pkg::*;

	cfg_t  cfg_q;
	link_t link_w;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width     <= CFG_W'(GRID_MAX);
			cfg_q.grid_height    <= CFG_W'(GRID_MAX);
			cfg_q.periodic_width <= '0;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_GRID_WIDTH:     cfg_q.grid_width     <= cfg.wdata;
				REG_GRID_HEIGHT:    cfg_q.grid_height    <= cfg.wdata;
				REG_PERIODIC_WIDTH: cfg_q.periodic_width <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Gather the input word
	assign link_w.pos_x           = links.pos_x;
	assign link_w.pos_y           = links.pos_y;
	assign link_w.dir_x           = links.dir_x;
	assign link_w.dir_y           = links.dir_y;
	assign link_w.wall_fraction   = links.wall_fraction;
	assign link_w.f_here          = links.f_here;
	assign link_w.f_upstream      = links.f_upstream;
	assign link_w.f_here_opposite = links.f_here_opposite;

	logic             fr_valid, fr_ready;
	logic [MAG_W-1:0] fr_mag;
	logic [DIV_W-1:0] fr_den2;
	side_t            fr_side;

	ibbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (links.valid),
		.in_ready  (links.ready),
		.in_link   (link_w),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_mag   (fr_mag),
		.out_den2  (fr_den2),
		.out_side  (fr_side)
	);

	logic             dv_valid, dv_ready;
	logic [QUO_W-1:0] dv_quo;
	side_t            dv_side;

	ibbl_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_mag    (fr_mag),
		.in_den2   (fr_den2),
		.in_side   (fr_side),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	// Undo the magnitude fold and saturate to the f range
	logic signed [QUO_W-1:0] qs;
	logic signed [F_W-1:0]   fsat;

	always_comb begin
		qs = dv_side.neg ? $signed(~dv_quo) : $signed(dv_quo);
		if (qs[QUO_W-1] != qs[F_W-1])
			fsat = qs[QUO_W-1] ? {1'b1, {(F_W-1){1'b0}}} : {1'b0, {(F_W-1){1'b1}}};
		else
			fsat = qs[F_W-1:0];
	end

	// Output register
	logic                   v_q;
	logic signed [F_W-1:0]  f_new_q;
	rule_t                  rule_q;
	logic signed [UP_W-1:0] ux_q, uy_q;

	assign dv_ready = !v_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (dv_ready)
			v_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (dv_ready && dv_valid) begin
			f_new_q <= fsat;
			rule_q  <= dv_side.rule;
			ux_q    <= dv_side.ux;
			uy_q    <= dv_side.uy;
		end
	end

	assign results.valid      = v_q;
	assign results.f_new      = f_new_q;
	assign results.rule_used  = rule_q;
	assign results.upstream_x = ux_q;
	assign results.upstream_y = uy_q;

endmodule

`default_nettype wire

FILE: dv/bounce_back_checker.sv
module bounce_back_checker (
	input  wire    clk,
	input  wire    arst_n,
	ibbl_link_if   links,
	ibbl_result_if results,
	ibbl_cfg_if    cfg,
	output int     mismatches,
	output int     in_flight
);
	import ibbl_pkg::*;

	localparam longint F_HI = (longint'(1) << (F_W - 1)) - 1;
	localparam longint F_LO = -(longint'(1) << (F_W - 1));

	typedef struct packed {
		logic signed [F_W-1:0]  f_new;
		rule_t                  rule;
		logic signed [UP_W-1:0] up_x;
		logic signed [UP_W-1:0] up_y;
	} bounce_result_t;

	cfg_t           regs;
	bounce_result_t pending_results[$];

	// floor of a / b for b > 0
	function automatic longint floor_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// Work out the bounced distribution and upstream cell for one link
	function automatic bounce_result_t predict_bounce(input link_t l, input cfg_t c);
		longint ux;
		longint uy;
		longint per;
		longint wf;
		longint fh;
		longint fu;
		longint fo;
		longint t;
		longint num;
		longint val;
		bounce_result_t r;
		ux  = longint'(l.pos_x) - longint'($signed(l.dir_x));
		uy  = longint'(l.pos_y) - longint'($signed(l.dir_y));
		per = longint'(c.periodic_width);
		wf  = longint'(l.wall_fraction);
		fh  = longint'($signed(l.f_here));
		fu  = longint'($signed(l.f_upstream));
		fo  = longint'($signed(l.f_here_opposite));

		// wrap x once into the period
		if (per > 0) begin
			if (ux < 0)
				ux = ux + per;
			else if (ux >= per)
				ux = ux - per;
		end

		if (wf < Q_HALF) begin
			if (ux >= 0 && ux < longint'(c.grid_width) &&
					uy >= 0 && uy < longint'(c.grid_height)) begin
				t      = 2 * wf;
				num    = t * fh + (Q_ONE - t) * fu;
				val    = floor_quot(2 * num + Q_ONE, 2 * Q_ONE);
				r.rule = RULE_NEAR;
			end else begin
				val    = fh;
				r.rule = RULE_HALF;
			end
		end else begin
			t      = 2 * wf;
			num    = fh * Q_ONE + (t - Q_ONE) * fo;
			val    = floor_quot(2 * num + t, 2 * t);
			r.rule = RULE_FAR;
		end

		// saturate to the distribution range
		if (val > F_HI)
			val = F_HI;
		else if (val < F_LO)
			val = F_LO;
		r.f_new = val[F_W-1:0];
		r.up_x  = ux[UP_W-1:0];
		r.up_y  = uy[UP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		link_t          l;
		bounce_result_t want;
		if (!arst_n) begin
			regs.grid_width     = CFG_W'(GRID_MAX);
			regs.grid_height    = CFG_W'(GRID_MAX);
			regs.periodic_width = '0;
			pending_results.delete();
			mismatches = 0;
			in_flight  = 0;
		end else begin
			// track register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					REG_GRID_WIDTH:     regs.grid_width     = cfg.wdata;
					REG_GRID_HEIGHT:    regs.grid_height    = cfg.wdata;
					REG_PERIODIC_WIDTH: regs.periodic_width = cfg.wdata;
					default: ;
				endcase
			end

			// predict each accepted link word
			if (links.valid && links.ready) begin
				l.pos_x           = links.pos_x;
				l.pos_y           = links.pos_y;
				l.dir_x           = links.dir_x;
				l.dir_y           = links.dir_y;
				l.wall_fraction   = links.wall_fraction;
				l.f_here          = links.f_here;
				l.f_upstream      = links.f_upstream;
				l.f_here_opposite = links.f_here_opposite;
				pending_results = {pending_results, predict_bounce(l, regs)};
			end

			// compare each result word with the oldest prediction
			if (results.valid && results.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word: f_new=%0d rule_used=%0d",
						results.f_new, results.rule_used);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (results.f_new !== want.f_new) begin
						$error("f_new: expected %0d, got %0d", want.f_new, results.f_new);
						mismatches++;
					end
					if (results.rule_used !== 2'(want.rule)) begin
						$error("rule_used: expected %0d, got %0d",
							2'(want.rule), results.rule_used);
						mismatches++;
					end
					if (results.upstream_x !== want.up_x) begin
						$error("upstream_x: expected %0d, got %0d",
							want.up_x, results.upstream_x);
						mismatches++;
					end
					if (results.upstream_y !== want.up_y) begin
						$error("upstream_y: expected %0d, got %0d",
							want.up_y, results.upstream_y);
						mismatches++;
					end
				end
			end
			in_flight = pending_results.size();
		end
	end

endmodule

FILE: dv/tb_interpolated_bounce_back_link_unit.sv
module tb_interpolated_bounce_back_link_unit;
	import ibbl_pkg::*;

	localparam int N_PHASES       = 8;
	localparam int PHASE_ITEMS    = 242;
	localparam int LONG_HOLD      = 300;
	localparam int TAIL_CYCLES    = 20;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int F_TOP          = 8388607;
	localparam int F_BOTTOM       = -8388608;

	logic clk;
	logic arst_n;

	int send_idle_pct;
	int stall_pct;
	int hold_requests;
	int chk_mismatches;
	int chk_in_flight;

	ibbl_link_if   links_bus ();
	ibbl_result_if results_bus ();
	ibbl_cfg_if    cfg_bus ();

	interpolated_bounce_back_link_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.links   (links_bus),
		.results (results_bus),
		.cfg     (cfg_bus)
	);

	bounce_back_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.links      (links_bus),
		.results    (results_bus),
		.cfg        (cfg_bus),
		.mismatches (chk_mismatches),
		.in_flight  (chk_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("tb_interpolated_bounce_back_link_unit NOT OK");
		$finish;
	end

	// Drive result ready: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		int seen;
		results_bus.ready = 1'b0;
		hold_left = 0;
		seen      = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen) begin
				seen      = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_bus.ready <= 1'b0;
			end else begin
				results_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic link_t mk_link(input int px, input int py, input int dx, input int dy,
			input int wf, input int fh, input int fu, input int fo);
		link_t l;
		l.pos_x           = POS_W'(px);
		l.pos_y           = POS_W'(py);
		l.dir_x           = DIR_W'(dx);
		l.dir_y           = DIR_W'(dy);
		l.wall_fraction   = WF_W'(wf);
		l.f_here          = F_W'(fh);
		l.f_upstream      = F_W'(fu);
		l.f_here_opposite = F_W'(fo);
		return l;
	endfunction

	// Positions cluster around the grid edges and the wrap point
	function automatic logic [POS_W-1:0] edge_pos(input logic [CFG_W-1:0] size,
			input logic [CFG_W-1:0] period);
		logic [CFG_W:0] base;
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: base = {1'b0, size};
			3: base = {1'b0, period};
			default: return POS_W'($urandom);
		endcase
		return POS_W'(base + $urandom_range(2) - 1);
	endfunction

	function automatic logic [WF_W-1:0] pick_fraction();
		case ($urandom_range(9))
			0: return '0;
			1: return WF_W'(Q_HALF - 1);
			2: return WF_W'(Q_HALF);
			3: return WF_W'(Q_ONE);
			4: return '1;
			5, 6: return WF_W'($urandom_range(Q_HALF - 1));
			7, 8: return WF_W'($urandom_range(Q_ONE, Q_HALF));
			default: return WF_W'($urandom);
		endcase
	endfunction

	function automatic logic [F_W-1:0] pick_f();
		case ($urandom_range(5))
			0: return F_W'(F_TOP);
			1: return F_W'(F_BOTTOM);
			2: return F_W'($urandom_range(6) - 3);
			default: return F_W'($urandom);
		endcase
	endfunction

	function automatic link_t random_link(input cfg_t c);
		link_t l;
		l.pos_x           = edge_pos(c.grid_width, c.periodic_width);
		l.pos_y           = edge_pos(c.grid_height, '0);
		l.dir_x           = DIR_W'($urandom);
		l.dir_y           = DIR_W'($urandom);
		l.wall_fraction   = pick_fraction();
		l.f_here          = pick_f();
		l.f_upstream      = pick_f();
		l.f_here_opposite = pick_f();
		return l;
	endfunction

	// Offer one link word after a random gap; valid stays high afterwards
	task automatic offer_link(input link_t l);
		while ($urandom_range(99) < send_idle_pct) begin
			links_bus.valid <= 1'b0;
			@(posedge clk);
		end
		links_bus.valid           <= 1'b1;
		links_bus.pos_x           <= l.pos_x;
		links_bus.pos_y           <= l.pos_y;
		links_bus.dir_x           <= l.dir_x;
		links_bus.dir_y           <= l.dir_y;
		links_bus.wall_fraction   <= l.wall_fraction;
		links_bus.f_here          <= l.f_here;
		links_bus.f_upstream      <= l.f_upstream;
		links_bus.f_here_opposite <= l.f_here_opposite;
		do @(posedge clk); while (!links_bus.ready);
	endtask

	// Register write; the caller drops valid after the last one
	task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.addr  <= idx;
		cfg_bus.wdata <= val;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic wait_links_done();
		links_bus.valid <= 1'b0;
		do @(negedge clk); while (chk_in_flight != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		cfg_t next;
		arst_n                    = 1'b0;
		send_idle_pct             = 0;
		stall_pct                 = 0;
		hold_requests             = 0;
		links_bus.valid           = 1'b0;
		links_bus.pos_x           = '0;
		links_bus.pos_y           = '0;
		links_bus.dir_x           = '0;
		links_bus.dir_y           = '0;
		links_bus.wall_fraction   = '0;
		links_bus.f_here          = '0;
		links_bus.f_upstream      = '0;
		links_bus.f_here_opposite = '0;
		cfg_bus.valid             = 1'b0;
		cfg_bus.addr              = REG_GRID_WIDTH;
		cfg_bus.wdata             = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed links under the reset grid
		// upstream below zero: halfway fallback with zero fraction
		offer_link(mk_link(0, 0, 1, 1, 0, 100, 200, 300));
		// zero fraction inside the grid gives f_upstream
		offer_link(mk_link(5, 5, 1, 0, 0, 100, 200, 300));
		// upstream one past the top corner
		offer_link(mk_link(4095, 4095, -1, -1, 100, 5000, -7000, 0));
		// direction pattern minus two, inside and outside
		offer_link(mk_link(10, 10, -2, -2, 1000, 123456, -654321, 0));
		offer_link(mk_link(4095, 0, -2, 0, 1000, 123456, -654321, 0));
		// largest near fraction with extreme distributions
		offer_link(mk_link(7, 7, 0, 0, Q_HALF - 1, F_TOP, F_BOTTOM, 0));
		offer_link(mk_link(7, 7, 0, 0, Q_HALF - 1, F_BOTTOM, F_TOP, 0));
		// rounding ties go toward plus infinity
		offer_link(mk_link(7, 7, 1, -1, Q_HALF / 2, 1, 0, 0));
		offer_link(mk_link(7, 7, 1, -1, Q_HALF / 2, -1, 0, 0));
		// far rule at one half, at one, and above one
		offer_link(mk_link(7, 7, 0, 1, Q_HALF, F_TOP, 0, F_BOTTOM));
		offer_link(mk_link(7, 7, 0, 1, Q_ONE, F_TOP, 0, F_BOTTOM));
		offer_link(mk_link(7, 7, -1, 0, 2 * Q_ONE - 1, F_BOTTOM, 0, F_TOP));
		offer_link(mk_link(7, 7, -1, 0, Q_ONE + Q_HALF, 3, 0, -5));
		offer_link(mk_link(4094, 4094, 1, 1, 20000, -1, F_TOP, 77));
		offer_link(mk_link(0, 4095, 0, 0, 2 * Q_ONE - 1, F_BOTTOM, F_BOTTOM, F_BOTTOM));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_links_done();

			// pick the grid for this phase
			case (ph)
				0: next = '{CFG_W'(4096), CFG_W'(4096), CFG_W'(0)};
				1: next = '{CFG_W'(4096), CFG_W'(4096), CFG_W'(4096)};
				2: next = '{CFG_W'(100), CFG_W'(60), CFG_W'(100)};
				3: next = '{CFG_W'(0), CFG_W'(4096), CFG_W'(0)};
				4: next = '{CFG_W'(4096), CFG_W'(0), CFG_W'(1)};
				5: next = '{CFG_W'(8191), CFG_W'(8191), CFG_W'(8191)};
				6: next = '{CFG_W'(1), CFG_W'(1), CFG_W'(4096)};
				default: begin
					next.grid_width     = CFG_W'($urandom_range(8191));
					next.grid_height    = CFG_W'($urandom_range(8191));
					next.periodic_width = CFG_W'($urandom_range(8191));
				end
			endcase
			write_reg(REG_GRID_WIDTH, next.grid_width);
			write_reg(REG_GRID_HEIGHT, next.grid_height);
			write_reg(REG_PERIODIC_WIDTH, next.periodic_width);
			cfg_bus.valid <= 1'b0;

			// rotate through idle patterns
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 70; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 70; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase

			// back up the pipe while links keep coming
			if (ph == 0 || ph == 5)
				hold_requests++;

			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_link(random_link(next));
		end

		wait_links_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (chk_mismatches == 0)
			$display("tb_interpolated_bounce_back_link_unit OK");
		else
			$display("tb_interpolated_bounce_back_link_unit NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/ibbl_pkg.sv
hdl/ibbl_if.sv
hdl/ibbl_front.sv
hdl/ibbl_divider.sv
hdl/interpolated_bounce_back_link_unit.sv
dv/bounce_back_checker.sv
dv/tb_interpolated_bounce_back_link_unit.sv
